[hw/rtl/z80s_pkg.sv]
// ----------------------------------------------------------------------------
// z80s_pkg: shared types and constants of the Z80 subset core
// Result kinds, opcodes, phase codes, the result record and the batch of
// results that one item produces.
// ----------------------------------------------------------------------------
package z80s_pkg;

  localparam int MaxResults = 3;

  // result kinds
  localparam logic [2:0] K_MRD  = 3'd0;
  localparam logic [2:0] K_MWR  = 3'd1;
  localparam logic [2:0] K_PRD  = 3'd2;
  localparam logic [2:0] K_PWR  = 3'd3;
  localparam logic [2:0] K_DONE = 3'd4;
  localparam logic [2:0] K_BANK = 3'd5;

  // input function codes
  localparam logic [1:0] F_STEP = 2'd0;
  localparam logic [1:0] F_DATA = 2'd1;
  localparam logic [1:0] F_BANK = 2'd2;

  // configuration register indexes
  localparam logic CFG_IMODE = 1'b0;
  localparam logic CFG_VPAGE = 1'b1;

  // opcodes
  localparam logic [7:0] OP_HALT  = 8'h76;
  localparam logic [7:0] OP_LDAN  = 8'h3E;
  localparam logic [7:0] OP_LDNNA = 8'h32;
  localparam logic [7:0] OP_LDANN = 8'h3A;
  localparam logic [7:0] OP_JP    = 8'hC3;
  localparam logic [7:0] OP_CALL  = 8'hCD;
  localparam logic [7:0] OP_RET   = 8'hC9;
  localparam logic [7:0] OP_OUT   = 8'hD3;
  localparam logic [7:0] OP_IN    = 8'hDB;
  localparam logic [7:0] OP_DI    = 8'hF3;
  localparam logic [7:0] OP_EI    = 8'hFB;
  localparam logic [7:0] OP_PFXCB = 8'hCB;
  localparam logic [7:0] OP_PFXDD = 8'hDD;
  localparam logic [7:0] OP_PFXED = 8'hED;
  localparam logic [7:0] OP_PFXFD = 8'hFD;

  // fixed addresses and reset values
  localparam logic [15:0] NMI_VEC  = 16'h0066;
  localparam logic [15:0] IRQ_VEC  = 16'h0038;
  localparam logic [15:0] SP_RESET = 16'hFFFF;
  localparam logic [7:0]  A_RESET  = 8'hFF;

  typedef enum logic [9:0] {
    PH_IDLE  = 10'b0000000001,
    PH_FETCH = 10'b0000000010,
    PH_IMM   = 10'b0000000100,
    PH_LOW   = 10'b0000001000,
    PH_HIGH  = 10'b0000010000,
    PH_DATA  = 10'b0000100000,
    PH_RETLO = 10'b0001000000,
    PH_RETHI = 10'b0010000000,
    PH_VECLO = 10'b0100000000,
    PH_VECHI = 10'b1000000000
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [4:0]  cycles;
    logic [23:0] bank_address;
  } result_t;

  typedef struct packed {
    result_t [MaxResults-1:0] res;
    logic [1:0]               count;
  } batch_t;

  function automatic result_t mk_result(logic [2:0] kind, logic [15:0] addr,
                                        logic [7:0] wdata, logic [4:0] cyc,
                                        logic [23:0] bank);
    result_t r;
    r.kind         = kind;
    r.address      = addr;
    r.write_data   = wdata;
    r.cycles       = cyc;
    r.bank_address = bank;
    return r;
  endfunction

endpackage

[hw/rtl/z80s_exec.sv]
// ----------------------------------------------------------------------------
// z80s_exec: architectural state and single-pass execute
// Holds the core registers and, for each accepted item, computes the next
// state and the batch of bus requests and step results in one pass.
// ----------------------------------------------------------------------------
module z80s_exec (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [1:0]          func,
  input  logic [7:0]          read_data,
  input  logic                bank_bit,
  input  logic                reset_level,
  input  logic                bus_request,
  input  logic                nmi_raise,
  input  logic                irq_raise,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data,
  output z80s_pkg::batch_t    batch
);

  logic [1:0]       imode_r, imode_nxt;
  logic [7:0]       vpage_r, vpage_nxt;
  logic [7:0]       acc_r, acc_nxt;
  logic [15:0]      sp_r, sp_nxt;
  logic [15:0]      pc_r, pc_nxt;
  logic [1:0]       ie_r, ie_nxt;
  logic             halt_r, halt_nxt;
  logic [1:0]       pend_r, pend_nxt;
  logic [8:0]       bank_r, bank_nxt;
  logic             rprev_r, rprev_nxt;
  z80s_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       opcode_r, opcode_nxt;
  logic [7:0]       oplow_r, oplow_nxt;

  always_comb begin
    logic [1:0]  n;
    logic [15:0] nn;
    logic [15:0] vaddr;

    imode_nxt  = imode_r;
    vpage_nxt  = vpage_r;
    acc_nxt    = acc_r;
    sp_nxt     = sp_r;
    pc_nxt     = pc_r;
    ie_nxt     = ie_r;
    halt_nxt   = halt_r;
    pend_nxt   = pend_r;
    bank_nxt   = bank_r;
    rprev_nxt  = rprev_r;
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    oplow_nxt  = oplow_r;
    batch      = '0;
    n          = 2'd0;
    nn         = {read_data, oplow_r};
    vaddr      = {vpage_r, 8'hFF};

    if (accept) begin
      // reset edge first, then raise inputs, then the function
      if (reset_level && !rprev_r) begin
        imode_nxt  = 2'd0;
        vpage_nxt  = 8'd0;
        acc_nxt    = z80s_pkg::A_RESET;
        sp_nxt     = z80s_pkg::SP_RESET;
        pc_nxt     = 16'd0;
        ie_nxt     = 2'd0;
        halt_nxt   = 1'b0;
        pend_nxt   = 2'd0;
        bank_nxt   = 9'd0;
        phase_nxt  = z80s_pkg::PH_IDLE;
        opcode_nxt = 8'd0;
        oplow_nxt  = 8'd0;
      end
      rprev_nxt = reset_level;
      pend_nxt  = pend_nxt | {irq_raise, nmi_raise};
      vaddr     = {vpage_nxt, 8'hFF};
      nn        = {read_data, oplow_nxt};

      case (func)
        z80s_pkg::F_STEP: begin
          if (reset_level || bus_request) begin
            batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_DONE, 16'd0, 8'd0, 5'd0, 24'd0);
            n = n + 2'd1;
          end else if (phase_nxt == z80s_pkg::PH_IDLE) begin
            if (pend_nxt[0] || (pend_nxt[1] && ie_nxt[0])) begin
              // push the return address, high byte first
              batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_MWR, sp_nxt - 16'd1,
                                                 pc_nxt[15:8], 5'd0, 24'd0);
              n = n + 2'd1;
              batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_MWR, sp_nxt - 16'd2,
                                                 pc_nxt[7:0], 5'd0, 24'd0);
              n = n + 2'd1;
              sp_nxt   = sp_nxt - 16'd2;
              halt_nxt = 1'b0;
              if (pend_nxt[0]) begin
                pend_nxt[0] = 1'b0;
                ie_nxt      = {ie_nxt[0], 1'b0};
                pc_nxt      = z80s_pkg::NMI_VEC;
                batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_DONE, 16'd0, 8'd0,
                                                   5'd11, 24'd0);
                n = n + 2'd1;
              end else begin
                pend_nxt[1] = 1'b0;
                ie_nxt      = 2'd0;
                if (!imode_nxt[1]) begin
                  pc_nxt = z80s_pkg::IRQ_VEC;
                  batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_DONE, 16'd0, 8'd0,
                                                     5'd13, 24'd0);
                  n = n + 2'd1;
                end else begin
                  batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_MRD, vaddr, 8'd0,
                                                     5'd0, 24'd0);
                  n = n + 2'd1;
                  phase_nxt = z80s_pkg::PH_VECLO;
                end
              end
            end else if (halt_nxt) begin
              batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_DONE, 16'd0, 8'd0, 5'd4, 24'd0);
              n = n + 2'd1;
            end else begin
              batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_MRD, pc_nxt, 8'd0, 5'd0, 24'd0);
              n = n + 2'd1;
              pc_nxt    = pc_nxt + 16'd1;
              phase_nxt = z80s_pkg::PH_FETCH;
            end
          end
        end
        z80s_pkg::F_DATA: begin
          case (phase_nxt)
            z80s_pkg::PH_FETCH: begin
              opcode_nxt = read_data;
              phase_nxt  = z80s_pkg::PH_IDLE;
              case (read_data)
                z80s_pkg::OP_HALT: begin
                  halt_nxt = 1'b1;
                  batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_DONE, 16'd0, 8'd0,
                                                     5'd4, 24'd0);
                  n = n + 2'd1;
                end
                z80s_pkg::OP_LDAN, z80s_pkg::OP_OUT, z80s_pkg::OP_IN,
                z80s_pkg::OP_LDNNA, z80s_pkg::OP_LDANN, z80s_pkg::OP_JP,
                z80s_pkg::OP_CALL: begin
                  batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_MRD, pc_nxt, 8'd0,
                                                     5'd0, 24'd0);
                  n = n + 2'd1;
                  pc_nxt = pc_nxt + 16'd1;
                  if (read_data == z80s_pkg::OP_LDAN || read_data == z80s_pkg::OP_OUT ||
                      read_data == z80s_pkg::OP_IN) begin
                    phase_nxt = z80s_pkg::PH_IMM;
                  end else begin
                    phase_nxt = z80s_pkg::PH_LOW;
                  end
                end
                z80s_pkg::OP_RET: begin
                  batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_MRD, sp_nxt, 8'd0,
                                                     5'd0, 24'd0);
                  n = n + 2'd1;
                  sp_nxt    = sp_nxt + 16'd1;
                  phase_nxt = z80s_pkg::PH_RETLO;
                end
                z80s_pkg::OP_DI, z80s_pkg::OP_EI: begin
                  ie_nxt = (read_data == z80s_pkg::OP_EI) ? 2'b11 : 2'b00;
                  batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_DONE, 16'd0, 8'd0,
                                                     5'd4, 24'd0);
                  n = n + 2'd1;
                end
                z80s_pkg::OP_PFXCB, z80s_pkg::OP_PFXDD, z80s_pkg::OP_PFXED,
                z80s_pkg::OP_PFXFD: begin
                  batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_DONE, 16'd0, 8'd0,
                                                     5'd8, 24'd0);
                  n = n + 2'd1;
                end
                default: begin
                  batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_DONE, 16'd0, 8'd0,
                                                     5'd4, 24'd0);
                  n = n + 2'd1;
                end
              endcase
            end
            z80s_pkg::PH_IMM: begin
              if (opcode_nxt == z80s_pkg::OP_LDAN) begin
                acc_nxt   = read_data;
                phase_nxt = z80s_pkg::PH_IDLE;
                batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_DONE, 16'd0, 8'd0,
                                                   5'd7, 24'd0);
                n = n + 2'd1;
              end else if (opcode_nxt == z80s_pkg::OP_OUT) begin
                batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_PWR, {8'd0, read_data},
                                                   acc_nxt, 5'd0, 24'd0);
                n = n + 2'd1;
                batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_DONE, 16'd0, 8'd0,
                                                   5'd11, 24'd0);
                n = n + 2'd1;
                phase_nxt = z80s_pkg::PH_IDLE;
              end else begin
                batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_PRD, {8'd0, read_data},
                                                   8'd0, 5'd0, 24'd0);
                n = n + 2'd1;
                phase_nxt = z80s_pkg::PH_DATA;
              end
            end
            z80s_pkg::PH_LOW: begin
              oplow_nxt = read_data;
              batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_MRD, pc_nxt, 8'd0, 5'd0, 24'd0);
              n = n + 2'd1;
              pc_nxt    = pc_nxt + 16'd1;
              phase_nxt = z80s_pkg::PH_HIGH;
            end
            z80s_pkg::PH_HIGH: begin
              phase_nxt = z80s_pkg::PH_IDLE;
              if (opcode_nxt == z80s_pkg::OP_LDNNA) begin
                batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_MWR, nn, acc_nxt,
                                                   5'd0, 24'd0);
                n = n + 2'd1;
                batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_DONE, 16'd0, 8'd0,
                                                   5'd13, 24'd0);
                n = n + 2'd1;
              end else if (opcode_nxt == z80s_pkg::OP_LDANN) begin
                batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_MRD, nn, 8'd0, 5'd0, 24'd0);
                n = n + 2'd1;
                phase_nxt = z80s_pkg::PH_DATA;
              end else if (opcode_nxt == z80s_pkg::OP_JP) begin
                pc_nxt = nn;
                batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_DONE, 16'd0, 8'd0,
                                                   5'd10, 24'd0);
                n = n + 2'd1;
              end else begin
                // call: push return address, then jump
                batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_MWR, sp_nxt - 16'd1,
                                                   pc_nxt[15:8], 5'd0, 24'd0);
                n = n + 2'd1;
                batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_MWR, sp_nxt - 16'd2,
                                                   pc_nxt[7:0], 5'd0, 24'd0);
                n = n + 2'd1;
                sp_nxt = sp_nxt - 16'd2;
                pc_nxt = nn;
                batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_DONE, 16'd0, 8'd0,
                                                   5'd17, 24'd0);
                n = n + 2'd1;
              end
            end
            z80s_pkg::PH_DATA: begin
              acc_nxt   = read_data;
              phase_nxt = z80s_pkg::PH_IDLE;
              batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_DONE, 16'd0, 8'd0,
                  (opcode_nxt == z80s_pkg::OP_LDANN) ? 5'd13 : 5'd11, 24'd0);
              n = n + 2'd1;
            end
            z80s_pkg::PH_RETLO: begin
              oplow_nxt = read_data;
              batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_MRD, sp_nxt, 8'd0, 5'd0, 24'd0);
              n = n + 2'd1;
              sp_nxt    = sp_nxt + 16'd1;
              phase_nxt = z80s_pkg::PH_RETHI;
            end
            z80s_pkg::PH_VECLO: begin
              oplow_nxt = read_data;
              batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_MRD, vaddr + 16'd1, 8'd0,
                                                 5'd0, 24'd0);
              n = n + 2'd1;
              phase_nxt = z80s_pkg::PH_VECHI;
            end
            z80s_pkg::PH_RETHI, z80s_pkg::PH_VECHI: begin
              pc_nxt    = nn;
              phase_nxt = z80s_pkg::PH_IDLE;
              batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_DONE, 16'd0, 8'd0,
                  (phase_nxt == z80s_pkg::PH_IDLE && phase_r == z80s_pkg::PH_RETHI &&
                   !(reset_level && !rprev_r)) ? 5'd10 : 5'd13, 24'd0);
              n = n + 2'd1;
            end
            default: begin
              // idle: no read pending, drop the data
              phase_nxt = z80s_pkg::PH_IDLE;
            end
          endcase
        end
        z80s_pkg::F_BANK: begin
          bank_nxt = {bank_bit, bank_nxt[8:1]};
          batch.res[n] = z80s_pkg::mk_result(z80s_pkg::K_BANK, 16'd0, 8'd0, 5'd0,
                                             {bank_nxt, 15'd0});
          n = n + 2'd1;
        end
        default: begin
        end
      endcase
    end

    if (cfg_we) begin
      case (cfg_index)
        z80s_pkg::CFG_IMODE: imode_nxt = cfg_data[1:0];
        z80s_pkg::CFG_VPAGE: vpage_nxt = cfg_data;
        default: begin
        end
      endcase
    end

    batch.count = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      imode_r  <= 2'd0;
      vpage_r  <= 8'd0;
      acc_r    <= z80s_pkg::A_RESET;
      sp_r     <= z80s_pkg::SP_RESET;
      pc_r     <= 16'd0;
      ie_r     <= 2'd0;
      halt_r   <= 1'b0;
      pend_r   <= 2'd0;
      bank_r   <= 9'd0;
      rprev_r  <= 1'b1;
      phase_r  <= z80s_pkg::PH_IDLE;
      opcode_r <= 8'd0;
      oplow_r  <= 8'd0;
    end else begin
      imode_r  <= imode_nxt;
      vpage_r  <= vpage_nxt;
      acc_r    <= acc_nxt;
      sp_r     <= sp_nxt;
      pc_r     <= pc_nxt;
      ie_r     <= ie_nxt;
      halt_r   <= halt_nxt;
      pend_r   <= pend_nxt;
      bank_r   <= bank_nxt;
      rprev_r  <= rprev_nxt;
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      oplow_r  <= oplow_nxt;
    end
  end

endmodule

[hw/rtl/z80s_outbuf.sv]
// ----------------------------------------------------------------------------
// z80s_outbuf: result buffer
// Holds the batch of up to three results of one item and hands them out one
// per handshake, marking the final one.
// ----------------------------------------------------------------------------
module z80s_outbuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  z80s_pkg::batch_t batch,
  output logic             out_valid,
  input  logic             out_ready,
  output z80s_pkg::result_t out_res,
  output logic             out_last
);

  z80s_pkg::result_t [z80s_pkg::MaxResults-1:0] entries_r, entries_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       fire;
  logic       load;

  assign out_valid = (cnt_r != 2'd0);
  assign out_last  = (idx_r == cnt_r - 2'd1);
  assign out_res   = entries_r[idx_r];
  assign fire      = out_valid && out_ready;
  // take the next item when the buffer is empty or while the final result of this one leaves
  assign in_ready  = !out_valid || (out_ready && out_last);
  assign load      = in_valid && in_ready && (batch.count != 2'd0);

  always_comb begin
    entries_nxt = entries_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    if (load) begin
      entries_nxt = batch.res;
      cnt_nxt     = batch.count;
      idx_nxt     = 2'd0;
    end else if (fire) begin
      if (out_last) begin
        cnt_nxt = 2'd0;
        idx_nxt = 2'd0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    entries_r <= entries_nxt;
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (idx_r < cnt_r))
    else $error("result index beyond batch count");

  a_empty_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> (idx_r == 2'd0))
    else $error("empty buffer with nonzero index");

  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (out_valid && idx_r == 2'd0))
    else $error("loaded batch does not start at first result");

  a_drain_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !out_last) |=> (out_valid && idx_r == $past(idx_r) + 2'd1))
    else $error("batch lost before final result");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("item accepted over a waiting result");

endmodule

[hw/rtl/z80_subset_core.sv]
// ----------------------------------------------------------------------------
// z80_subset_core: bus-mastering Z80 subset core
// Latency: results of an item appear the cycle after it is accepted.
// Results: the results of an item leave the result buffer one per handshake;
// an item with no result is taken without loading anything into the buffer.
// A new item is taken in the cycle its predecessor's final result leaves.
// Reset: rst_n is synchronous, active low; it clears all core state.
// ----------------------------------------------------------------------------
module z80_subset_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_read_data,
  input  logic        in_bank_bit,
  input  logic        in_reset_level,
  input  logic        in_bus_request,
  input  logic        in_nmi_raise,
  input  logic        in_irq_raise,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [15:0] out_address,
  output logic [7:0]  out_write_data,
  output logic [4:0]  out_cycles,
  output logic [23:0] out_bank_address,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  z80s_pkg::batch_t  batch;
  z80s_pkg::result_t out_res;
  logic              accept;

  assign accept = in_valid && in_ready;

  z80s_exec u_exec (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .func        (in_func),
    .read_data   (in_read_data),
    .bank_bit    (in_bank_bit),
    .reset_level (in_reset_level),
    .bus_request (in_bus_request),
    .nmi_raise   (in_nmi_raise),
    .irq_raise   (in_irq_raise),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .batch       (batch)
  );

  z80s_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .batch     (batch),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res),
    .out_last  (out_last)
  );

  assign out_kind         = out_res.kind;
  assign out_address      = out_res.address;
  assign out_write_data   = out_res.write_data;
  assign out_cycles       = out_res.cycles;
  assign out_bank_address = out_res.bank_address;

endmodule

[tb/z80_subset_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z80_subset_checker: result checker for the Z80 subset core
// Mirrors the core state and configuration, predicts the bus requests and
// step completions of every accepted item, and compares each accepted result
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module z80_subset_checker
  import z80s_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_read_data,
  input  logic        in_bank_bit,
  input  logic        in_reset_level,
  input  logic        in_bus_request,
  input  logic        in_nmi_raise,
  input  logic        in_irq_raise,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_kind,
  input  logic [15:0] out_address,
  input  logic [7:0]  out_write_data,
  input  logic [4:0]  out_cycles,
  input  logic [23:0] out_bank_address,
  input  logic        out_last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output int unsigned fail_count,
  output int unsigned pending_results
);

  typedef struct packed {
    result_t res;
    logic    last;
  } bus_op_t;

  bus_op_t expected_ops[$];
  bus_op_t item_ops[$];

  logic [1:0]  irq_mode;
  logic [7:0]  vec_page;
  logic [7:0]  acc;
  logic [15:0] sp;
  logic [15:0] pc;
  logic        iff1;
  logic        iff2;
  logic        halted;
  logic        nmi_pend;
  logic        irq_pend;
  logic [8:0]  bank;
  logic        rst_line_q;
  phase_t      ph;
  logic [7:0]  op_q;
  logic [7:0]  lo_q;

  function automatic void reset_core();
    irq_mode = 2'd0;
    vec_page = 8'd0;
    acc      = A_RESET;
    sp       = SP_RESET;
    pc       = 16'd0;
    iff1     = 1'b0;
    iff2     = 1'b0;
    halted   = 1'b0;
    nmi_pend = 1'b0;
    irq_pend = 1'b0;
    bank     = 9'd0;
    ph       = PH_IDLE;
    op_q     = 8'd0;
    lo_q     = 8'd0;
  endfunction

  function automatic void issue(logic [2:0] kind, logic [15:0] addr, logic [7:0] wdata,
                                logic [4:0] cyc, logic [23:0] base);
    bus_op_t op;
    op.res.kind         = kind;
    op.res.address      = addr;
    op.res.write_data   = wdata;
    op.res.cycles       = cyc;
    op.res.bank_address = base;
    op.last             = 1'b0;
    if (item_ops.size() < MaxResults) item_ops.push_back(op);
  endfunction

  function automatic void read_mem(logic [15:0] addr, phase_t next);
    issue(K_MRD, addr, 8'd0, 5'd0, 24'd0);
    ph = next;
  endfunction

  function automatic void end_step(logic [4:0] cyc);
    issue(K_DONE, 16'd0, 8'd0, cyc, 24'd0);
    ph = PH_IDLE;
  endfunction

  function automatic logic [15:0] take_pc();
    logic [15:0] a;
    a  = pc;
    pc = pc + 16'd1;
    return a;
  endfunction

  // high byte goes first, one below the stack pointer
  function automatic void push_pc();
    sp = sp - 16'd1;
    issue(K_MWR, sp, pc[15:8], 5'd0, 24'd0);
    sp = sp - 16'd1;
    issue(K_MWR, sp, pc[7:0], 5'd0, 24'd0);
  endfunction

  function automatic void run_step(logic blocked);
    if (blocked) begin
      issue(K_DONE, 16'd0, 8'd0, 5'd0, 24'd0);
    end else if (ph != PH_IDLE) begin
      // drop: a read is still outstanding
    end else if (nmi_pend) begin
      nmi_pend = 1'b0;
      iff2     = iff1;
      iff1     = 1'b0;
      halted   = 1'b0;
      push_pc();
      pc = NMI_VEC;
      end_step(5'd11);
    end else if (irq_pend && iff1) begin
      irq_pend = 1'b0;
      iff1     = 1'b0;
      iff2     = 1'b0;
      halted   = 1'b0;
      push_pc();
      if (irq_mode < 2'd2) begin
        pc = IRQ_VEC;
        end_step(5'd13);
      end else begin
        read_mem({vec_page, 8'hFF}, PH_VECLO);
      end
    end else if (halted) begin
      end_step(5'd4);
    end else begin
      read_mem(take_pc(), PH_FETCH);
    end
  endfunction

  function automatic void decode(logic [7:0] op);
    op_q = op;
    case (op)
      OP_HALT: begin
        halted = 1'b1;
        end_step(5'd4);
      end
      OP_LDAN, OP_OUT, OP_IN: read_mem(take_pc(), PH_IMM);
      OP_LDNNA, OP_LDANN, OP_JP, OP_CALL: read_mem(take_pc(), PH_LOW);
      OP_RET: begin
        read_mem(sp, PH_RETLO);
        sp = sp + 16'd1;
      end
      OP_DI: begin
        iff1 = 1'b0;
        iff2 = 1'b0;
        end_step(5'd4);
      end
      OP_EI: begin
        iff1 = 1'b1;
        iff2 = 1'b1;
        end_step(5'd4);
      end
      OP_PFXCB, OP_PFXDD, OP_PFXED, OP_PFXFD: end_step(5'd8);
      default: end_step(5'd4);
    endcase
  endfunction

  function automatic void apply_data(logic [7:0] d);
    logic [15:0] nn;
    nn = {d, lo_q};
    case (ph)
      PH_FETCH: decode(d);
      PH_IMM: begin
        if (op_q == OP_LDAN) begin
          acc = d;
          end_step(5'd7);
        end else if (op_q == OP_OUT) begin
          issue(K_PWR, {8'd0, d}, acc, 5'd0, 24'd0);
          end_step(5'd11);
        end else begin
          issue(K_PRD, {8'd0, d}, 8'd0, 5'd0, 24'd0);
          ph = PH_DATA;
        end
      end
      PH_LOW: begin
        lo_q = d;
        read_mem(take_pc(), PH_HIGH);
      end
      PH_HIGH: begin
        if (op_q == OP_LDNNA) begin
          issue(K_MWR, nn, acc, 5'd0, 24'd0);
          end_step(5'd13);
        end else if (op_q == OP_LDANN) begin
          read_mem(nn, PH_DATA);
        end else if (op_q == OP_JP) begin
          pc = nn;
          end_step(5'd10);
        end else begin
          push_pc();
          pc = nn;
          end_step(5'd17);
        end
      end
      PH_DATA: begin
        acc = d;
        end_step((op_q == OP_LDANN) ? 5'd13 : 5'd11);
      end
      PH_RETLO: begin
        lo_q = d;
        read_mem(sp, PH_RETHI);
        sp = sp + 16'd1;
      end
      PH_RETHI: begin
        pc = nn;
        end_step(5'd10);
      end
      PH_VECLO: begin
        lo_q = d;
        // second vector byte; the address wraps within 16 bits
        read_mem({vec_page, 8'hFF} + 16'd1, PH_VECHI);
      end
      PH_VECHI: begin
        pc = nn;
        end_step(5'd13);
      end
      default: ph = PH_IDLE;
    endcase
  endfunction

  function automatic void predict_item();
    item_ops.delete();
    if (in_reset_level && !rst_line_q) reset_core();
    rst_line_q = in_reset_level;
    if (in_nmi_raise) nmi_pend = 1'b1;
    if (in_irq_raise) irq_pend = 1'b1;
    case (in_func)
      F_STEP: run_step(in_reset_level || in_bus_request);
      F_DATA: if (ph != PH_IDLE) apply_data(in_read_data);
      F_BANK: begin
        bank = {in_bank_bit, bank[8:1]};
        issue(K_BANK, 16'd0, 8'd0, 5'd0, {bank, 15'd0});
      end
      default: ;
    endcase
    if (item_ops.size() > 0) item_ops[item_ops.size()-1].last = 1'b1;
    foreach (item_ops[i]) expected_ops.push_back(item_ops[i]);
  endfunction

  function automatic void match_field(string name, logic [23:0] want, logic [23:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    bus_op_t want;
    if (!rst_n) begin
      reset_core();
      rst_line_q = 1'b1;
      expected_ops.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_IMODE) irq_mode = cfg_data[1:0];
        else vec_page = cfg_data;
      end
      if (in_valid && in_ready) predict_item();
      if (out_valid && out_ready) begin
        if (expected_ops.size() == 0) begin
          fail_count++;
          $display("%0t ns: result kind %0d, expected none", $time, out_kind);
        end else begin
          want = expected_ops.pop_front();
          match_field("kind", want.res.kind, out_kind);
          match_field("address", want.res.address, out_address);
          match_field("write_data", want.res.write_data, out_write_data);
          match_field("cycles", want.res.cycles, out_cycles);
          match_field("bank_address", want.res.bank_address, out_bank_address);
          match_field("last", want.last, out_last);
        end
      end
    end
    pending_results = expected_ops.size();
  end

endmodule

[tb/tb_z80_subset_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_z80_subset_core: testbench top for the Z80 subset core
// Plays the memory and bus side: runs a directed opening, then random
// instruction, interrupt, bank and reset sequences under several interrupt
// settings, with random idling on both channels and one long output stall.
// The checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_z80_subset_core;
  import z80s_pkg::*;

  localparam logic [1:0] F_NONE = 2'd3;
  localparam int LongHold = 60;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_func;
  logic [7:0]  in_read_data;
  logic        in_bank_bit;
  logic        in_reset_level;
  logic        in_bus_request;
  logic        in_nmi_raise;
  logic        in_irq_raise;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_kind;
  logic [15:0] out_address;
  logic [7:0]  out_write_data;
  logic [4:0]  out_cycles;
  logic [23:0] out_bank_address;
  logic        out_last;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_data;
  int unsigned fail_count;
  int unsigned pending_results;

  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  bit long_hold_req = 1'b0;
  int hold_cycles = 0;
  int items_counted = 0;

  // what the stimulus expects the core to be doing
  bit         gen_halted;
  bit         gen_iff;
  bit         gen_irq_pend;
  logic [1:0] gen_mode;

  logic [7:0] opcode_pool [16] = '{OP_HALT, OP_LDAN, OP_LDNNA, OP_LDANN, OP_JP, OP_CALL,
                                   OP_RET, OP_OUT, OP_IN, OP_DI, OP_EI, OP_EI,
                                   OP_PFXCB, OP_PFXDD, OP_PFXED, OP_PFXFD};

  z80_subset_core u_top (.*);

  z80_subset_checker u_checker (.*);

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // result side: short random stalls, plus one long hold on request
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_cycles = LongHold - 1;
      out_ready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
      hold_cycles = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(input logic [1:0] func, input logic [7:0] data, input logic bbit,
                           input logic rlev, input logic busreq, input logic nmi,
                           input logic irq);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= func;
    in_read_data   <= data;
    in_bank_bit    <= bbit;
    in_reset_level <= rlev;
    in_bus_request <= busreq;
    in_nmi_raise   <= nmi;
    in_irq_raise   <= irq;
    do @(posedge clk); while (!in_ready);
    items_counted++;
    @(negedge clk);
  endtask

  task automatic send_step(input logic rlev, input logic busreq, input logic nmi,
                           input logic irq);
    send_item(F_STEP, $urandom_range(0, 255), $urandom_range(0, 1), rlev, busreq, nmi, irq);
  endtask

  task automatic send_data(input logic [7:0] d);
    send_item(F_DATA, d, $urandom_range(0, 1), 1'b0, 1'b0, 1'b0, 1'b0);
  endtask

  // one step and the reads it will ask for
  task automatic step_seq(input bit nmi, input bit irq);
    logic [7:0] op;
    send_step(1'b0, 1'b0, nmi, irq);
    if (irq) gen_irq_pend = 1'b1;
    if (nmi) begin
      gen_iff    = 1'b0;
      gen_halted = 1'b0;
    end else if (gen_irq_pend && gen_iff) begin
      gen_irq_pend = 1'b0;
      gen_iff      = 1'b0;
      gen_halted   = 1'b0;
      if (gen_mode >= 2'd2) repeat (2) send_data($urandom_range(0, 255));
    end else if (!gen_halted) begin
      op = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                       : opcode_pool[$urandom_range(0, 15)];
      send_data(op);
      case (op)
        OP_HALT: gen_halted = 1'b1;
        OP_DI: gen_iff = 1'b0;
        OP_EI: gen_iff = 1'b1;
        OP_LDAN, OP_OUT: send_data($urandom_range(0, 255));
        OP_IN, OP_LDNNA, OP_JP, OP_CALL, OP_RET: repeat (2) send_data($urandom_range(0, 255));
        OP_LDANN: repeat (3) send_data($urandom_range(0, 255));
        default: ;
      endcase
    end
  endtask

  task automatic write_settings(input logic [1:0] mode, input logic [7:0] page);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IMODE;
    cfg_data  <= {6'd0, mode};
    @(negedge clk);
    cfg_index <= CFG_VPAGE;
    cfg_data  <= page;
    @(negedge clk);
    cfg_we <= 1'b0;
    gen_mode = mode;
  endtask

  // drain all results, then give the core time to finish a silent item
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic directed();
    send_data(8'h55);
    send_item(F_NONE, 8'hAA, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    send_item(F_BANK, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    send_item(F_BANK, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_step(1'b0, 1'b1, 1'b0, 1'b0);
    send_step(1'b0, 1'b0, 1'b0, 1'b0);
    // step while the fetch is outstanding is dropped
    send_step(1'b0, 1'b0, 1'b0, 1'b0);
    send_data(OP_EI);
    // vector table at page FF: second read wraps to 0000
    send_step(1'b0, 1'b0, 1'b0, 1'b1);
    send_data(8'h00);
    send_data(8'h80);
    send_step(1'b0, 1'b0, 1'b1, 1'b0);
    send_step(1'b0, 1'b0, 1'b0, 1'b0);
    send_data(OP_PFXCB);
    send_step(1'b0, 1'b0, 1'b0, 1'b0);
    send_data(OP_HALT);
    send_step(1'b0, 1'b0, 1'b0, 1'b0);
    send_step(1'b0, 1'b0, 1'b1, 1'b0);
    send_step(1'b1, 1'b0, 1'b0, 1'b0);
    send_step(1'b0, 1'b0, 1'b0, 1'b0);
    send_data(OP_IN);
    send_data(8'hFF);
    send_data(8'h00);
    gen_halted   = 1'b0;
    gen_iff      = 1'b0;
    gen_irq_pend = 1'b0;
    gen_mode     = 2'd0;
  endtask

  task automatic run_random(input int target, input bit calm);
    int base;
    int seqs;
    int pick;
    base = items_counted;
    seqs = 0;
    while (items_counted - base < target) begin
      if (calm) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end else if (seqs % 12 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      seqs++;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        if (gen_halted && $urandom_range(0, 1) == 0) step_seq(1'b1, 1'b0);
        else step_seq(1'b0, 1'b0);
      end else if (pick < 68) begin
        step_seq(1'b1, $urandom_range(0, 1));
      end else if (pick < 78) begin
        step_seq(1'b0, 1'b1);
      end else if (pick < 86) begin
        repeat ($urandom_range(1, 3))
          send_item(F_BANK, $urandom_range(0, 255), $urandom_range(0, 1), 1'b0, 1'b0,
                    1'b0, 1'b0);
      end else if (pick < 90) begin
        send_step(1'b0, 1'b1, 1'b0, 1'b0);
      end else if (pick < 93) begin
        // reset line pulse: clears the core and both registers
        send_step(1'b1, $urandom_range(0, 1), 1'b0, 1'b0);
        if ($urandom_range(0, 1) == 0)
          send_item(F_BANK, $urandom_range(0, 255), $urandom_range(0, 1), 1'b1, 1'b0,
                    1'b0, 1'b0);
        gen_halted   = 1'b0;
        gen_iff      = 1'b0;
        gen_irq_pend = 1'b0;
        gen_mode     = 2'd0;
      end else begin
        send_item(($urandom_range(0, 1) != 0) ? F_DATA : F_NONE, $urandom_range(0, 255),
                  $urandom_range(0, 1), 1'b0, 1'b0, 1'b0, 1'b0);
        items_counted--;
      end
    end
  endtask

  initial begin
    int guard;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = F_STEP;
    in_read_data   = 8'd0;
    in_bank_bit    = 1'b0;
    in_reset_level = 1'b0;
    in_bus_request = 1'b0;
    in_nmi_raise   = 1'b0;
    in_irq_raise   = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_IMODE;
    cfg_data       = 8'd0;
    gen_halted     = 1'b0;
    gen_iff        = 1'b0;
    gen_irq_pend   = 1'b0;
    gen_mode       = 2'd0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_settings(2'd2, 8'hFF);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    directed();

    settle();
    write_settings(2'd0, 8'h00);
    run_random(80, 1'b0);

    settle();
    write_settings(2'd1, $urandom_range(0, 255));
    run_random(40, 1'b0);
    // hold the result side while items keep coming
    long_hold_req = 1'b1;
    run_random(40, 1'b1);

    settle();
    write_settings(2'd2, 8'hFF);
    run_random(80, 1'b0);

    settle();
    write_settings(2'd2, 8'h00);
    run_random(80, 1'b0);

    settle();
    write_settings($urandom_range(0, 2), $urandom_range(0, 255));
    run_random(40, 1'b0);
    run_random(40, 1'b1);

    in_valid <= 1'b0;
    guard = 0;
    while (pending_results != 0 && guard < 2000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
